// File: hw/rtl/palx_pkg.sv
// Shared types and constants for the path arc-length index block.
// No dependencies; imported by palx_ram users and path_arc_length_index.
package palx_pkg;

   localparam int IDX_W          = 10;
   localparam int LEN_W          = 39;
   localparam int COORD_W        = 24;
   localparam int ABS_W          = 40;
   localparam int WIN_W          = 40;
   localparam int SQ_W           = 50;
   localparam int MAX_POINTS_DEF = 1024;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ARC   = 2'd1,
      OP_INDEX = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOLOAD = 2'd1,
      ST_FULL   = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LD_MX,
      S_LD_MY,
      S_LD_SQRT,
      S_LD_WR,
      S_BS_RD,
      S_BS_CMP,
      S_RD_A,
      S_A_CAP,
      S_DN_RD,
      S_DN_CHK,
      S_UP_RD,
      S_UP_CHK,
      S_FINISH
   } state_type;

endpackage

// File: hw/rtl/path_arc_length_index.sv
// Top level: polyline loader with cumulative arc-length table and window search.
// Depends on palx_pkg and palx_ram.
//
//   channel | ports          | direction | contents
//   req     | req_valid/stall | in       | load point or query transaction
//   rsp     | rsp_valid/stall | out      | one result per request transaction
//
// Load: squares dx and dy, then 25 square-root iterations on one shared
// compare/subtract unit; a first point goes straight to the table write. Query:
// an in-range abscissa query does a binary search over the table, then each query
// walks the window entry by entry, all through the single read port of the table RAM.
// A dropped point, an unused opcode or a rejected query goes straight to finish.
// Reset is synchronous and clears the path; the table needs no clearing.
// A result waits in an output register; rsp_stall only holds the next finish.
module path_arc_length_index #(
   parameter int MAX_POINTS = palx_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic                                req_first_point,
   input  logic signed [palx_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [palx_pkg::COORD_W-1:0] req_y_coord,
   input  logic signed [palx_pkg::ABS_W-1:0]   req_query_abscissa,
   input  logic [palx_pkg::IDX_W-1:0]          req_query_index,
   input  logic [palx_pkg::WIN_W-1:0]          req_window_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [palx_pkg::IDX_W-1:0]          rsp_center_index,
   output logic [palx_pkg::IDX_W-1:0]          rsp_min_index,
   output logic [palx_pkg::IDX_W-1:0]          rsp_max_index,
   output logic [palx_pkg::LEN_W-1:0]          rsp_path_length,
   output logic [palx_pkg::IDX_W-1:0]          rsp_written_index
);
   import palx_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int QW = (CW > IDX_W) ? CW : IDX_W;
   localparam int RW = 25;
   localparam int PW = 2 * COORD_W;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]         q_ff, q_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic [COORD_W-1:0]       x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0]       lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic [COORD_W-1:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0]          rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [CW-1:0]            n_ff, n_in, count_ff, count_in;
   logic [LEN_W-1:0]         total_ff, total_in, a_ff, a_in;
   logic [CW-1:0]            lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]            mid_ff, mid_in;
   logic [AW-1:0]            c_ff, c_in, mn_ff, mn_in, mx_ff, mx_in, wr_ff, wr_in;
   logic [1:0]               st_ff, st_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]         rsp_c_ff, rsp_c_in, rsp_mn_ff, rsp_mn_in;
   logic [IDX_W-1:0]         rsp_mx_ff, rsp_mx_in, rsp_wr_ff, rsp_wr_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;

   // table RAM
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [LEN_W-1:0]         ram_wdata, ram_rdata;

   palx_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // decode conditions shared by sequencer and datapath
   logic                     acc;
   logic [CW-1:0]            cnt_eff;
   logic                     full_eff, few_pts, idx_bad, q_low, q_high;
   logic [AW-1:0]            last_idx;
   logic signed [COORD_W:0]  dx, dy;
   logic [CW:0]              mid_sum;
   logic [CW-1:0]            mid_w;
   logic                     bs_go, bs_less;
   logic [LEN_W-1:0]         dn_diff, up_diff;
   logic                     dn_ok, up_ok, out_free;
   logic [COORD_W-1:0]       mul_a;
   logic [PW-1:0]            mul_p;
   logic [SQ_W-1:0]          sq_try;
   logic                     sq_ge;
   logic [ABS_W-1:0]         sat_sum;

   assign acc      = req_valid && (state_ff == S_IDLE);
   assign cnt_eff  = req_first_point ? '0 : count_ff;
   assign full_eff = (cnt_eff >= CW'(MAX_POINTS));
   assign few_pts  = (count_ff < CW'(2));
   assign idx_bad  = (QW'(req_query_index) >= QW'(count_ff));
   assign q_low    = req_query_abscissa[ABS_W-1] || (req_query_abscissa == '0);
   assign q_high   = (req_query_abscissa[LEN_W-1:0] >= total_ff);
   assign last_idx = AW'(count_ff - CW'(1));

   assign dx = $signed({req_x_coord[COORD_W-1], req_x_coord})
             - $signed({lastx_ff[COORD_W-1], lastx_ff});
   assign dy = $signed({req_y_coord[COORD_W-1], req_y_coord})
             - $signed({lasty_ff[COORD_W-1], lasty_ff});

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w   = mid_sum[CW:1];
   assign bs_go   = (lo_ff < hi_ff);
   assign bs_less = (ram_rdata < q_ff);

   assign dn_diff = a_ff - ram_rdata;
   assign up_diff = ram_rdata - a_ff;
   assign dn_ok   = ({dn_diff, 1'b0} < win_ff);
   assign up_ok   = ({up_diff, 1'b0} < win_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared squaring multiplier and square-root step
   assign mul_a   = (state_ff == S_LD_MX) ? ax_ff : ay_ff;
   assign mul_p   = mul_a * mul_a;
   assign sq_try  = res_ff + bit_ff;
   assign sq_ge   = (rem_ff >= sq_try);
   assign sat_sum = {1'b0, total_ff} + ABS_W'(res_ff[RW-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  if (full_eff)           state_in = S_FINISH;
                  else if (cnt_eff == '0) state_in = S_LD_WR;
                  else                    state_in = S_LD_MX;
               end else if (req_op == OP_NONE || few_pts) begin
                  state_in = S_FINISH;
               end else if (req_op == OP_INDEX) begin
                  state_in = idx_bad ? S_FINISH : S_RD_A;
               end else begin
                  state_in = (q_low || q_high) ? S_RD_A : S_BS_RD;
               end
            end
         end
         S_LD_MX:   state_in = S_LD_MY;
         S_LD_MY:   state_in = S_LD_SQRT;
         S_LD_SQRT: state_in = bit_ff[0] ? S_LD_WR : S_LD_SQRT;
         S_LD_WR:   state_in = S_FINISH;
         S_BS_RD:   state_in = bs_go ? S_BS_CMP : S_RD_A;
         S_BS_CMP:  state_in = S_BS_RD;
         S_RD_A:    state_in = S_A_CAP;
         S_A_CAP:   state_in = S_DN_RD;
         S_DN_RD:   state_in = (mn_ff == '0) ? S_UP_RD : S_DN_CHK;
         S_DN_CHK:  state_in = dn_ok ? S_DN_RD : S_UP_RD;
         S_UP_RD:   state_in = (mx_ff == last_idx) ? S_FINISH : S_UP_CHK;
         S_UP_CHK:  state_in = up_ok ? S_UP_RD : S_FINISH;
         S_FINISH:  state_in = out_free ? S_IDLE : S_FINISH;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_in = q_ff;     win_in = win_ff;
      x_in = x_ff;     y_in = y_ff;   lastx_in = lastx_ff; lasty_in = lasty_ff;
      ax_in = ax_ff;   ay_in = ay_ff;
      rem_in = rem_ff; res_in = res_ff; bit_in = bit_ff;
      n_in = n_ff;     count_in = count_ff; total_in = total_ff; a_in = a_ff;
      lo_in = lo_ff;   hi_in = hi_ff; mid_in = mid_ff;
      c_in = c_ff;     mn_in = mn_ff; mx_in = mx_ff; wr_in = wr_ff; st_in = st_ff;
      ram_we = 1'b0;   ram_waddr = n_ff[AW-1:0]; ram_wdata = '0; ram_raddr = c_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_c_in = rsp_c_ff; rsp_mn_in = rsp_mn_ff; rsp_mx_in = rsp_mx_ff;
      rsp_wr_in = rsp_wr_ff; rsp_len_in = rsp_len_ff;

      case (state_ff)
         // capture transaction and decide its path
         S_IDLE: begin
            if (acc) begin
               q_in   = req_query_abscissa[LEN_W-1:0];
               win_in = req_window_length;
               x_in   = req_x_coord;
               y_in   = req_y_coord;
               ax_in  = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
               ay_in  = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
               n_in   = cnt_eff;
               c_in = '0; mn_in = '0; mx_in = '0; wr_in = '0;
               st_in  = ST_OK;
               lo_in  = '0;
               hi_in  = count_ff;
               if (req_op == OP_LOAD) begin
                  if (full_eff) st_in = ST_FULL;
               end else if (req_op == OP_NONE) begin
                  st_in = ST_RANGE;
               end else if (few_pts) begin
                  st_in = ST_NOLOAD;
               end else if (req_op == OP_INDEX) begin
                  if (idx_bad) st_in = ST_RANGE;
                  else         c_in  = AW'(req_query_index);
               end else if (q_high && !q_low) begin
                  c_in = last_idx;
               end
            end
         end
         // square dx, then accumulate dy squared
         S_LD_MX: rem_in = SQ_W'(mul_p);
         S_LD_MY: begin
            rem_in = rem_ff + SQ_W'(mul_p);
            res_in = '0;
            bit_in = SQ_W'(1) << (PW);
         end
         // one root bit per cycle
         S_LD_SQRT: begin
            if (sq_ge) begin
               rem_in = rem_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         // store cumulative length, saturated
         S_LD_WR: begin
            ram_we    = 1'b1;
            ram_waddr = n_ff[AW-1:0];
            if (n_ff == '0)            ram_wdata = '0;
            else if (sat_sum[LEN_W])   ram_wdata = LEN_MAX;
            else                       ram_wdata = sat_sum[LEN_W-1:0];
            total_in = ram_wdata;
            count_in = n_ff + CW'(1);
            lastx_in = x_ff;
            lasty_in = y_ff;
            wr_in    = n_ff[AW-1:0];
         end
         // lower-bound search over the table
         S_BS_RD: begin
            ram_raddr = mid_w[AW-1:0];
            mid_in    = mid_w[AW-1:0];
            if (!bs_go) c_in = lo_ff[AW-1:0];
         end
         S_BS_CMP: begin
            if (bs_less) lo_in = CW'(mid_ff) + CW'(1);
            else         hi_in = CW'(mid_ff);
         end
         // fetch centre length
         S_RD_A: begin
            ram_raddr = c_ff;
            mn_in     = c_ff;
            mx_in     = c_ff;
         end
         S_A_CAP: a_in = ram_rdata;
         // widen downward
         S_DN_RD:  ram_raddr = mn_ff;
         S_DN_CHK: if (dn_ok) mn_in = mn_ff - AW'(1);
         // widen upward
         S_UP_RD:  ram_raddr = mx_ff;
         S_UP_CHK: if (up_ok) mx_in = mx_ff + AW'(1);
         // hand result to the output register
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_c_in      = IDX_W'(c_ff);
               rsp_mn_in     = IDX_W'(mn_ff);
               rsp_mx_in     = IDX_W'(mx_ff);
               rsp_wr_in     = IDX_W'(wr_ff);
               rsp_len_in    = total_ff;
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         lastx_ff     <= '0;
         lasty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         lastx_ff     <= lastx_in;
         lasty_ff     <= lasty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff   <= q_in;    win_ff <= win_in;
      x_ff   <= x_in;    y_ff <= y_in;
      ax_ff  <= ax_in;   ay_ff <= ay_in;
      rem_ff <= rem_in;  res_ff <= res_in; bit_ff <= bit_in;
      n_ff   <= n_in;    a_ff <= a_in;
      lo_ff  <= lo_in;   hi_ff <= hi_in; mid_ff <= mid_in;
      c_ff   <= c_in;    mn_ff <= mn_in; mx_ff <= mx_in; wr_ff <= wr_in;
      st_ff  <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_c_ff  <= rsp_c_in;  rsp_mn_ff <= rsp_mn_in;
      rsp_mx_ff <= rsp_mx_in; rsp_wr_ff <= rsp_wr_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_center_index  = rsp_c_ff;
   assign rsp_min_index     = rsp_mn_ff;
   assign rsp_max_index     = rsp_mx_ff;
   assign rsp_path_length   = rsp_len_ff;
   assign rsp_written_index = rsp_wr_ff;

endmodule

// File: hw/rtl/palx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module palx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
